FILE: hw/rtl/sexp_tokenizer_unit_defines.svh
// Assertion macros used by the tokenizer checker.
`ifndef SEXP_TOKENIZER_UNIT_DEFINES_SVH
`define SEXP_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define SEXP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define SEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sexp_pkg.sv
// Package with the token codes, lexer modes and character constants of the tokenizer.
package sexp_pkg;

	typedef enum logic [2:0] {
		KIND_OPEN      = 3'd0,
		KIND_CLOSE     = 3'd1,
		KIND_WORD_BYTE = 3'd2,
		KIND_STR_BYTE  = 3'd3,
		KIND_WORD_END  = 3'd4,
		KIND_STR_END   = 3'd5
	} tok_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_WORD   = 2'd1,
		MODE_STRING = 2'd2
	} lex_mode_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} tok_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Depth of the result queue: one waiting result plus a two-result beat.
	localparam int QDEPTH = 3;

endpackage

FILE: hw/rtl/sexp_tokenizer_unit.sv
// S-expression tokenizer: byte-serial lexer with a three-entry result queue.
//
//  channel | direction | handshake               | payload
//  text    | in        | text_valid / text_stall | text_byte
//  token   | out       | token_valid/token_stall | token_kind, token_byte, run_last
//
// One text beat is accepted per cycle while at most one result waits in the queue.
// The lexer state is updated at the accepting edge; its results join the queue behind any
// waiting ones. A byte that yields two results (word end then paren) raises text_stall,
// set by queue occupancy alone; else, with token unstalled, text runs at one byte per cycle.
// Reset clears the lexer mode, both prior bytes and the queue.
module sexp_tokenizer_unit import sexp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [2:0] token_kind,
	output logic [7:0] token_byte,
	output logic       run_last
);

	lex_mode_t  mode_q;
	logic [7:0] prior_q;
	logic [7:0] prior2_q;
	tok_t       queue_q [QDEPTH];
	logic [1:0] cnt_q;

	lex_mode_t  mode_d;
	logic [1:0] n_res;
	tok_t       res0;
	tok_t       res1;
	logic       push;
	logic       pop;
	logic [1:0] base;
	logic       is_delim;
	logic       is_paren;
	logic       is_white;
	tok_kind_t  paren_kind;

	assign text_stall  = cnt_q[1];
	assign token_valid = (cnt_q != 2'd0);
	assign push        = text_valid && !text_stall;
	assign pop         = token_valid && !token_stall;
	assign base        = cnt_q - {1'b0, pop};

	assign token_kind = queue_q[0].kind;
	assign token_byte = queue_q[0].data;
	assign run_last   = queue_q[0].last;

	always_comb begin
		is_white   = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
		             (text_byte == CH_LF) || (text_byte == CH_CR);
		is_paren   = (text_byte == CH_OPEN) || (text_byte == CH_CLOSE);
		is_delim   = is_white || is_paren;
		paren_kind = (text_byte == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
		n_res      = 2'd0;
		mode_d     = mode_q;
		res0       = '{kind: KIND_OPEN, data: 8'h00, last: 1'b1};
		res1       = '{kind: KIND_OPEN, data: 8'h00, last: 1'b1};
		if (text_byte == CH_NUL) begin
			mode_d = MODE_IDLE;
			if (mode_q == MODE_WORD) begin
				n_res     = 2'd1;
				res0.kind = KIND_WORD_END;
			end
		end else begin
			unique case (mode_q)
				MODE_STRING: begin
					n_res = 2'd1;
					// A quote closes unless a lone backslash escapes it.
					if (text_byte == CH_QUOTE &&
					    (prior_q != CH_BSLASH || prior2_q == CH_BSLASH)) begin
						res0.kind = KIND_STR_END;
						mode_d    = MODE_IDLE;
					end else begin
						res0.kind = KIND_STR_BYTE;
						res0.data = text_byte;
					end
				end
				MODE_WORD: begin
					n_res = 2'd1;
					if (is_delim) begin
						res0.kind = KIND_WORD_END;
						mode_d    = MODE_IDLE;
						if (is_paren) begin
							n_res     = 2'd2;
							res0.last = 1'b0;
							res1.kind = paren_kind;
						end
					end else begin
						res0.kind = KIND_WORD_BYTE;
						res0.data = text_byte;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					if (text_byte == CH_QUOTE) begin
						mode_d = MODE_STRING;
					end else if (is_paren) begin
						n_res     = 2'd1;
						res0.kind = paren_kind;
					end else if (!is_white) begin
						n_res     = 2'd1;
						res0.kind = KIND_WORD_BYTE;
						res0.data = text_byte;
						mode_d    = MODE_WORD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			prior_q  <= 8'h00;
			prior2_q <= 8'h00;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				mode_q   <= mode_d;
				// End of text clears history, so the next text starts as after reset.
				prior_q  <= (text_byte == CH_NUL) ? 8'h00 : text_byte;
				prior2_q <= (text_byte == CH_NUL) ? 8'h00 : prior_q;
				cnt_q    <= base + n_res;
			end else begin
				cnt_q <= base;
			end
		end
	end

	// Queue payload: shift on pop, then place new results just above the survivors.
	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (push && n_res != 2'd0 && base == 2'(i)) begin
				queue_q[i] <= res0;
			end else if (push && n_res == 2'd2 && base + 2'd1 == 2'(i)) begin
				queue_q[i] <= res1;
			end else if (pop && i + 1 < QDEPTH) begin
				queue_q[i] <= queue_q[(i + 1) % QDEPTH];
			end
		end
	end

endmodule

FILE: hw/rtl/sexp_tokenizer_unit_checker.sv
// Port-level checker for the tokenizer, with its bind to the top level.
`include "sexp_tokenizer_unit_defines.svh"

module sexp_tokenizer_unit_checker import sexp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       token_valid,
	input logic       token_stall,
	input logic [2:0] token_kind,
	input logic [7:0] token_byte,
	input logic       run_last
);

	// A stalled result beat stays put.
	`SEXP_ASSERT_NEXT(a_token_hold, token_valid && token_stall, token_valid && $stable(token_kind) && $stable(token_byte) && $stable(run_last), "stalled token beat changed")

	// Only six token codes exist.
	`SEXP_ASSERT_NOW(a_kind_range, token_valid, token_kind <= KIND_STR_END, "token kind out of range")

	// Marks and parens carry no byte.
	`SEXP_ASSERT_NOW(a_byte_zero, token_valid && token_kind != KIND_WORD_BYTE && token_kind != KIND_STR_BYTE, token_byte == 8'h00, "non-byte token carries data")

	// A paren or a string end is always the final result of its byte.
	`SEXP_ASSERT_NOW(a_final_mark, token_valid && (token_kind == KIND_OPEN || token_kind == KIND_CLOSE || token_kind == KIND_STR_END), run_last, "paren or string end not last")

endmodule

bind sexp_tokenizer_unit sexp_tokenizer_unit_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token_kind  (token_kind),
	.token_byte  (token_byte),
	.run_last    (run_last)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the S-expression tokenizer: streams text bytes and checks every token.
`timescale 1ns / 100ps

module tb_top;
	import sexp_pkg::*;

	localparam int WATCH_LIMIT = 2000;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       text_valid  = 1'b0;
	logic       text_stall;
	logic [7:0] text_byte   = 8'h00;
	logic       token_valid;
	logic       token_stall = 1'b0;
	logic [2:0] token_kind;
	logic [7:0] token_byte;
	logic       run_last;

	// Lexer state as predicted by the testbench.
	lex_mode_t  cur_mode = MODE_IDLE;
	logic [7:0] last_b   = 8'h00;
	logic [7:0] last2_b  = 8'h00;

	tok_t pending_tokens[$];
	tok_t want;
	int   errors       = 0;
	int   bytes_sent   = 0;
	int   quiet_cycles = 0;
	int   stall_left   = 0;
	bit   watch_en     = 1'b0;
	bit   tx_idle_on   = 1'b1;
	bit   rx_idle_on   = 1'b1;

	sexp_tokenizer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_byte   (text_byte),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.token_byte  (token_byte),
		.run_last    (run_last)
	);

	always #1 clk = ~clk;

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(9, 40);
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic tok_t mk_tok(input tok_kind_t k, input logic [7:0] d);
		tok_t t;
		t.kind = k;
		t.data = d;
		t.last = 1'b0;
		return t;
	endfunction

	// Works out the tokens that one text byte causes and queues them in order.
	task automatic lex_byte(input logic [7:0] c);
		tok_t      r[2];
		int        n;
		lex_mode_t m;
		bit        delim;
		n = 0;
		m = cur_mode;
		delim = is_blank(c) || c == CH_OPEN || c == CH_CLOSE;
		if (c == CH_NUL) begin
			if (m == MODE_WORD) begin
				r[n] = mk_tok(KIND_WORD_END, 8'h00);
				n++;
			end
			cur_mode = MODE_IDLE;
			last_b = 8'h00;
			last2_b = 8'h00;
		end else begin
			if (m == MODE_STRING) begin
				// A quote after exactly one backslash is escaped; after two it closes.
				if (c == CH_QUOTE && (last_b != CH_BSLASH || last2_b == CH_BSLASH)) begin
					r[n] = mk_tok(KIND_STR_END, 8'h00);
					n++;
					m = MODE_IDLE;
				end else begin
					r[n] = mk_tok(KIND_STR_BYTE, c);
					n++;
				end
			end else begin
				if (m == MODE_WORD) begin
					if (delim) begin
						r[n] = mk_tok(KIND_WORD_END, 8'h00);
						n++;
						m = MODE_IDLE;
					end else begin
						r[n] = mk_tok(KIND_WORD_BYTE, c);
						n++;
					end
				end else begin
					m = MODE_IDLE;
					if (c == CH_QUOTE) begin
						m = MODE_STRING;
					end else if (!delim) begin
						r[n] = mk_tok(KIND_WORD_BYTE, c);
						n++;
						m = MODE_WORD;
					end
				end
				if (m == MODE_IDLE) begin
					if (c == CH_OPEN) begin
						r[n] = mk_tok(KIND_OPEN, 8'h00);
						n++;
					end else if (c == CH_CLOSE) begin
						r[n] = mk_tok(KIND_CLOSE, 8'h00);
						n++;
					end
				end
			end
			cur_mode = m;
			last2_b = last_b;
			last_b = c;
		end
		if (n > 0)
			r[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_tokens = {pending_tokens, r[i]};
	endtask

	// Sends one text beat after an optional gap and waits until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? pick_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (text_stall);
		lex_byte(b);
		bytes_sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_special();
		case ($urandom_range(0, 7))
			0: return CH_OPEN;
			1: return CH_CLOSE;
			2: return CH_QUOTE;
			3: return CH_BSLASH;
			4: return CH_SPACE;
			5: return CH_TAB;
			6: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_word_char();
		logic [7:0] c;
		if ($urandom_range(0, 9) == 0)
			return CH_QUOTE;
		do c = 8'($urandom_range(1, 255));
		while (is_blank(c) || c == CH_OPEN || c == CH_CLOSE || c == CH_QUOTE);
		return c;
	endfunction

	task automatic test_directed();
		send_str("(a)");
		send_byte(CH_SPACE); send_byte(8'hFF); send_byte(CH_OPEN);
		// Escaped quote, then a quote after two backslashes which closes.
		send_byte(CH_TAB); send_str("\"x\\\"y\\\\\"");
		send_byte(CH_LF); send_str("q\""); send_byte(CH_CR);
		send_byte(8'h01); send_byte(8'h80); send_byte(CH_NUL);
		send_str("\"z"); send_byte(CH_NUL);
		send_byte(CH_NUL);
		send_byte(CH_CLOSE); send_byte(CH_NUL);
	endtask

	task automatic test_well_formed();
		int depth;
		int ntok;
		int len;
		bit broken;
		while (bytes_sent < 1350) begin
			depth = 0;
			broken = 1'b0;
			ntok = $urandom_range(1, 20);
			for (int t = 0; t < ntok && !broken; t++) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						send_byte(CH_OPEN);
						depth++;
					end
					2, 3: begin
						if (depth > 0) begin
							send_byte(CH_CLOSE);
							depth--;
						end
					end
					4, 5, 6: begin
						len = $urandom_range(1, 6);
						for (int i = 0; i < len; i++)
							send_byte(pick_word_char());
						if ($urandom_range(0, 14) == 0)
							broken = 1'b1;
					end
					7, 8: begin
						send_byte(CH_QUOTE);
						len = $urandom_range(0, 8);
						for (int i = 0; i < len; i++) begin
							case ($urandom_range(0, 9))
								0, 1: send_byte(CH_BSLASH);
								2: begin
									send_byte(CH_BSLASH);
									send_byte(CH_QUOTE);
								end
								default: send_byte(pick_word_char());
							endcase
						end
						// Now and then the text ends inside the string.
						if ($urandom_range(0, 14) == 0)
							broken = 1'b1;
						else
							send_byte(CH_QUOTE);
					end
					default: send_byte(is_blank(pick_special()) ? CH_SPACE : CH_TAB);
				endcase
				if (!broken && $urandom_range(0, 2) == 0)
					send_byte($urandom_range(0, 1) ? CH_SPACE : CH_LF);
			end
			while (depth > 0 && !broken) begin
				send_byte(CH_CLOSE);
				depth--;
			end
			send_byte(CH_NUL);
		end
	endtask

	task automatic test_noise();
		int r;
		for (int i = 0; i < 350; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				send_byte(CH_NUL);
			else if (r < 40)
				send_byte(pick_special());
			else
				send_byte(8'($urandom_range(1, 255)));
		end
		send_byte(CH_NUL);
	endtask

	// No idling on either side, with many bytes that give two tokens.
	task automatic test_full_rate();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < 150; i++) begin
			if ($urandom_range(0, 2) == 0)
				send_byte($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
			else
				send_byte(pick_word_char());
		end
		send_byte(CH_NUL);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			token_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
			token_stall <= 1'b1;
			stall_left = pick_len() - 1;
		end else begin
			token_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			if (pending_tokens.size() == 0) begin
				$display("%0t: token with none expected: kind %0d byte %02h last %0d",
					$time, token_kind, token_byte, run_last);
				errors++;
			end else begin
				want = pending_tokens.pop_front();
				if (token_kind !== want.kind) begin
					$display("%0t: token_kind expected %0d actual %0d", $time, want.kind, token_kind);
					errors++;
				end
				if (token_byte !== want.data) begin
					$display("%0t: token_byte expected %02h actual %02h", $time, want.data, token_byte);
					errors++;
				end
				if (run_last !== want.last) begin
					$display("%0t: run_last expected %0d actual %0d", $time, want.last, run_last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!watch_en || (text_valid && !text_stall) || (token_valid && !token_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		watch_en = 1'b1;
		test_directed();
		test_well_formed();
		test_noise();
		test_full_rate();
		@(negedge clk);
		text_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		watch_en = 1'b0;
		// Keep the clock running so that any stray token still shows up.
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
